@@ src/sktab_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_pkg
// Shared widths, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sktab_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int NAME_W   = 64;
  localparam int MARKS_W  = 10;
  localparam int STATUS_W = 3;

  typedef logic [CMD_W-1:0]    command_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam command_t CMD_INSERT = 2'd0;
  localparam command_t CMD_DELETE = 2'd1;
  localparam command_t CMD_SEARCH = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_DELETED   = 3'd3;
  localparam status_t ST_FOUND     = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    do_insert;
    logic    do_delete;
    logic    load_out;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic any_match;
    logic full;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ src/sktab_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_ctrl
// Command sequencer: takes one word, resolves its status from the cell
// compare results and issues the table update and result load.
// ----------------------------------------------------------------------------
module sktab_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sktab_pkg::command_t in_command,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire sktab_pkg::dp_sts_t  sts,
  output sktab_pkg::dp_cmd_t       cmd
);

  sktab_pkg::state_t   state_r, state_nxt;
  sktab_pkg::command_t cmd_r, cmd_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sktab_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.status    = sktab_pkg::ST_NOT_FOUND;
    case (state_r)
      sktab_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sktab_pkg::S_EXEC;
        end
      end
      sktab_pkg::S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = sktab_pkg::S_IDLE;
          case (cmd_r)
            sktab_pkg::CMD_INSERT: begin
              if (sts.any_match) begin
                cmd.status = sktab_pkg::ST_DUPLICATE;
              end else if (sts.full) begin
                cmd.status = sktab_pkg::ST_FULL;
              end else begin
                cmd.status    = sktab_pkg::ST_INSERTED;
                cmd.do_insert = 1'b1;
              end
            end
            sktab_pkg::CMD_DELETE: begin
              if (sts.any_match) begin
                cmd.status    = sktab_pkg::ST_DELETED;
                cmd.do_delete = 1'b1;
              end
            end
            sktab_pkg::CMD_SEARCH: begin
              if (sts.any_match) begin
                cmd.status = sktab_pkg::ST_FOUND;
              end
            end
            default: begin
              cmd.status = sktab_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = sktab_pkg::S_IDLE;
      end
    endcase
  end

  assign cmd_nxt       = cmd.load_in ? in_command : cmd_r;
  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  assign out_valid     = out_valid_r;

endmodule
`default_nettype wire

@@ src/sktab_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_dp
// Row of record cells kept in ascending key order. Every cell compares its
// key with the latched key at once and shifts up or down on insert/delete.
// ----------------------------------------------------------------------------
module sktab_dp #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sktab_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [sktab_pkg::KEY_W-1:0]      in_key,
  input  wire logic [sktab_pkg::NAME_W-1:0]     in_name_code,
  input  wire logic [sktab_pkg::MARKS_W-1:0]    in_marks,
  input  wire sktab_pkg::dp_cmd_t               cmd,
  output sktab_pkg::dp_sts_t                    sts,
  output logic [sktab_pkg::STATUS_W-1:0]        out_status,
  output logic [sktab_pkg::NAME_W-1:0]          out_found_name,
  output logic [sktab_pkg::MARKS_W-1:0]         out_found_marks
);

  // only key bits below both the port width and KEY_BITS take part
  localparam int KW    = (KEY_BITS < sktab_pkg::KEY_W) ? KEY_BITS : sktab_pkg::KEY_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KW-1:0]                  key_r;
  logic [sktab_pkg::NAME_W-1:0]   name_r;
  logic [sktab_pkg::MARKS_W-1:0]  marks_r;
  logic [CNT_W-1:0]               count_r, count_nxt;

  logic [KW-1:0]                  cell_key_r   [CAPACITY];
  logic [sktab_pkg::NAME_W-1:0]   cell_name_r  [CAPACITY];
  logic [sktab_pkg::MARKS_W-1:0]  cell_marks_r [CAPACITY];

  logic [CAPACITY-1:0]            match;
  logic [CAPACITY-1:0]            less;
  logic                           any_match;
  logic [sktab_pkg::NAME_W-1:0]   hit_name;
  logic [sktab_pkg::MARKS_W-1:0]  hit_marks;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r   <= in_key[KW-1:0];
      name_r  <= in_name_code;
      marks_r <= in_marks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic valid;
    assign valid    = CNT_W'(i) < count_r;
    assign match[i] = valid && (cell_key_r[i] == key_r);
    assign less[i]  = valid && (cell_key_r[i] < key_r);

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (i == 0) begin
          if (!less[0]) begin
            cell_key_r[0]   <= key_r;
            cell_name_r[0]  <= name_r;
            cell_marks_r[0] <= marks_r;
          end
        end else if (!less[i]) begin
          if (less[(i == 0) ? 0 : i - 1]) begin
            cell_key_r[i]   <= key_r;
            cell_name_r[i]  <= name_r;
            cell_marks_r[i] <= marks_r;
          end else begin
            cell_key_r[i]   <= cell_key_r[(i == 0) ? 0 : i - 1];
            cell_name_r[i]  <= cell_name_r[(i == 0) ? 0 : i - 1];
            cell_marks_r[i] <= cell_marks_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd.do_delete) begin
        // every cell at or above the hit, but the top cell, pulls from its upper neighbor
        if ((i < CAPACITY - 1) && !less[i]) begin
          cell_key_r[i]   <= cell_key_r[(i < CAPACITY - 1) ? i + 1 : i];
          cell_name_r[i]  <= cell_name_r[(i < CAPACITY - 1) ? i + 1 : i];
          cell_marks_r[i] <= cell_marks_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign any_match = |match;

  always_comb begin
    hit_name  = '0;
    hit_marks = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_name  = hit_name  | ({sktab_pkg::NAME_W{match[i]}} & cell_name_r[i]);
      hit_marks = hit_marks | ({sktab_pkg::MARKS_W{match[i]}} & cell_marks_r[i]);
    end
  end

  assign sts.any_match = any_match;
  assign sts.full      = (count_r == CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.status;
      if (cmd.status == sktab_pkg::ST_FOUND) begin
        out_found_name  <= hit_name;
        out_found_marks <= hit_marks;
      end else begin
        out_found_name  <= '0;
        out_found_marks <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sorted_key_record_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_record_table
// Keyed record table held in ascending key order with insert, delete and
// search commands; one status word per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: command,
//   key, name_code and marks. Result channel (out_valid/out_ready) returns
//   exactly one word per command: status, found_name and found_marks.
//   Names and marks read back as zero unless the status is found.
// Operation:
//   A word is taken in the idle state and resolved in the execute state,
//   when every cell compares its key with the latched key and the row
//   shifts for an insert or delete. The result is registered as the word
//   is resolved; no new word is taken until the last one is resolved.
// Stall:
//   The result register holds while out_ready is low. A new word may still
//   be taken, but it is not resolved until the held result is taken.
// Reset:
//   rst_n (synchronous, active low) empties the table; record contents are
//   not cleared and are never read past the fill count.
// ----------------------------------------------------------------------------
module sorted_key_record_table #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sktab_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sktab_pkg::CMD_W-1:0]      in_command,
  input  wire logic [sktab_pkg::KEY_W-1:0]      in_key,
  input  wire logic [sktab_pkg::NAME_W-1:0]     in_name_code,
  input  wire logic [sktab_pkg::MARKS_W-1:0]    in_marks,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sktab_pkg::STATUS_W-1:0]        out_status,
  output logic [sktab_pkg::NAME_W-1:0]          out_found_name,
  output logic [sktab_pkg::MARKS_W-1:0]         out_found_marks
);

  sktab_pkg::dp_cmd_t dp_cmd;
  sktab_pkg::dp_sts_t dp_sts;

  // sequence: take word, resolve, load result
  sktab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // record cells, compare and shift, result register
  sktab_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key          (in_key),
    .in_name_code    (in_name_code),
    .in_marks        (in_marks),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .out_status      (out_status),
    .out_found_name  (out_found_name),
    .out_found_marks (out_found_marks)
  );

`ifndef SYNTH
  // one command in flight: a taken word blocks the next
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while another is being resolved");

  // payload fields are zero unless the record was found
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sktab_pkg::ST_FOUND) |->
      (out_found_name == '0) && (out_found_marks == '0))
    else $error("nonzero payload on a status other than found");

  // an insert never coincides with a full-table or duplicate report
  a_update_status: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.do_insert |-> !dp_sts.full && !dp_sts.any_match)
    else $error("insert issued into a full table or over a duplicate key");

  // a result only appears after a word was taken
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a command being resolved");
`endif

endmodule
`default_nettype wire
